FILE: hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam int HASH_ROTATE = 5;
    localparam int NUMBER_MAX = 15;

    typedef struct packed {
        logic       in_argument;
        logic       argument_start;
        logic [3:0] argument_number;
        logic       line_end;
        logic [4:0] argument_count;
        logic [7:0] name_hash;
    } t_result;

endpackage

FILE: hw/rtl/clt_core.sv
`timescale 1ns / 1ps

module clt_core #(
    parameter int MAX_ARGS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_char,
    output clt_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        MODE_BETWEEN    = 2'd0,
        MODE_PLAIN      = 2'd1,
        MODE_QUOTE_OPEN = 2'd2,
        MODE_QUOTE_TEXT = 2'd3
    } t_mode;

    localparam logic [4:0] COUNT_LIMIT = (MAX_ARGS > 31) ? 5'd31 : 5'(MAX_ARGS);

    t_mode      r_mode, n_mode;
    logic [7:0] r_hash, n_hash;
    logic       r_hash_active, n_hash_active;
    logic [4:0] r_args, n_args;

    logic       term;
    logic       printable;
    logic       text;
    logic       start;
    logic       count_up;
    logic [4:0] number;

    assign term      = (i_char < clt_pkg::SPACE_BYTE) || i_char[7];
    assign printable = (i_char > clt_pkg::SPACE_BYTE) && !i_char[7];

    always_comb begin
        n_hash        = r_hash;
        n_hash_active = r_hash_active;
        if (r_hash_active) begin
            if (printable) begin
                n_hash = ((r_hash << clt_pkg::HASH_ROTATE)
                         | (r_hash >> (8 - clt_pkg::HASH_ROTATE))) ^ i_char;
            end else begin
                n_hash_active = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        text     = 1'b0;
        start    = 1'b0;
        count_up = 1'b0;
        if (!term) begin
            unique case (r_mode)
                MODE_BETWEEN: begin
                    if (i_char == clt_pkg::QUOTE_BYTE) begin
                        count_up = 1'b1;
                        n_mode   = MODE_QUOTE_OPEN;
                    end else if (i_char > clt_pkg::SPACE_BYTE) begin
                        count_up = 1'b1;
                        n_mode   = MODE_PLAIN;
                        text     = 1'b1;
                        start    = 1'b1;
                    end
                end
                MODE_PLAIN: begin
                    if (i_char > clt_pkg::SPACE_BYTE) begin
                        text = 1'b1;
                    end else begin
                        n_mode = MODE_BETWEEN;
                    end
                end
                default: begin
                    if (i_char == clt_pkg::QUOTE_BYTE) begin
                        n_mode = MODE_BETWEEN;
                    end else begin
                        text   = 1'b1;
                        start  = (r_mode == MODE_QUOTE_OPEN);
                        n_mode = MODE_QUOTE_TEXT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_args = r_args;
        if (count_up && (r_args < COUNT_LIMIT)) begin
            n_args = r_args + 5'd1;
        end
        if (n_args == 5'd0) begin
            number = 5'd0;
        end else begin
            number = n_args - 5'd1;
        end
        if (number > 5'(clt_pkg::NUMBER_MAX)) begin
            number = 5'(clt_pkg::NUMBER_MAX);
        end
    end

    always_comb begin
        o_result.in_argument     = text;
        o_result.argument_start  = start;
        o_result.argument_number = text ? number[3:0] : 4'd0;
        o_result.line_end        = term;
        o_result.argument_count  = n_args;
        o_result.name_hash       = n_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_BETWEEN;
            r_hash        <= 8'd0;
            r_hash_active <= 1'b1;
            r_args        <= 5'd0;
        end else if (i_en) begin
            if (term) begin
                r_mode        <= MODE_BETWEEN;
                r_hash        <= 8'd0;
                r_hash_active <= 1'b1;
                r_args        <= 5'd0;
            end else begin
                r_mode        <= n_mode;
                r_hash        <= n_hash;
                r_hash_active <= n_hash_active;
                r_args        <= n_args;
            end
        end
    end

endmodule

FILE: hw/rtl/command_line_tokenizer_unit.sv
`timescale 1ns / 1ps
// command-line tokenizer: one raw byte in, one marked byte out
// slave channel s_axis_*: tdata[7:0] is the byte, one transfer per byte
// master channel m_axis_*: one transfer per input byte, tlast marks the
// byte that ends the line (below 0x20 or 0x80 and above); totals on that
// transfer are final for the line
// each byte passes through the input register and then the tokenizer step
// into the result register; throughput is one byte per cycle while the
// master channel does not stall; the scan state (mode, hash, count) is
// updated in the same cycle that a byte moves into the result register
// a stalled master channel holds the result; the input register still
// takes one byte, after that s_axis_tready drops until m_axis_tready
// returns
// reset (synchronous, i_rst_n low) empties both registers and returns the
// scan state to between arguments, hash zero, count zero; a line end does
// the same for the next line
module command_line_tokenizer_unit #(
    parameter int MAX_ARGS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // char_in[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // in_argument[0], argument_start[1], argument_number[5:2],
    // argument_count[10:6], name_hash[18:11], zero[23:19]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast   // line_end
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_out_valid;
    clt_pkg::t_result r_out;
    clt_pkg::t_result step_result;
    logic             out_free;
    logic             advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    clt_core #(
        .MAX_ARGS(MAX_ARGS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_char  (r_in_char),
        .o_result(step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.line_end;
    assign m_axis_tdata  = {5'd0, r_out.name_hash, r_out.argument_count,
                            r_out.argument_number, r_out.argument_start,
                            r_out.in_argument};

`ifndef SYNTHESIS
    localparam logic [4:0] CHECK_LIMIT = (MAX_ARGS > 31) ? 5'd31 : 5'(MAX_ARGS);

    // the line-ending byte is never argument text
    a_end_no_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == 2'b00))
        else $error("line end flagged as argument text");

    // a start byte is always text
    a_start_is_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("argument start without text");

    // count saturates at the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:6] <= CHECK_LIMIT))
        else $error("argument count above limit");

    // no new item enters the result register while a stalled result waits
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result overwritten during stall");
`endif

endmodule
